[hw/rtl/brm_pkg.sv]
// shared types, constants and helpers of the binary descriptor ratio matcher
package brm_pkg;

    localparam int WORD_W    = 64;
    localparam int DESC_MAX  = 256;
    localparam int DIST_W    = 9;
    localparam int IDX_W     = 11;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int Q_FRAC    = 8;

    // distance is summed as four partial counts of 64 bits each
    localparam int PART_N         = 4;
    localparam int PART_W         = 7;
    localparam int BYTES_PER_PART = DESC_MAX / 8 / PART_N;

    // register reset values
    localparam logic [CFG_W-1:0] RST_INIT_DIST = 9'd256;
    localparam logic [CFG_W-1:0] RST_THRESH    = 9'd50;
    localparam logic [CFG_W-1:0] RST_RATIO     = 9'd154;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_CAND  = 2'd1,
        FUNC_CLEAR = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_MATCH  = 2'd0,
        ST_REJECT = 2'd1,
        ST_RATIO  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_DIST = 2'd0,
        CFG_THRESH    = 2'd1,
        CFG_RATIO     = 2'd2
    } t_cfg_idx;

    // control of one item as it moves down the pipeline
    typedef struct packed {
        logic             load;
        logic             cand;
        logic             usable;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_stage;

    // request to mark an index in the used map
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_mark;

    typedef logic [PART_N-1:0][PART_W-1:0] t_parts;

    // number of set bits in one byte
    function automatic logic [3:0] popcnt8(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(b[i]);
        end
        return n;
    endfunction

endpackage

[hw/rtl/brm_dist.sv]
// query register and first distance stage: xor and partial bit counts
module brm_dist #(
    parameter int DESC_BITS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic                         i_cand,
    input  logic [brm_pkg::DESC_MAX-1:0] i_desc,
    output brm_pkg::t_parts              o_parts
);
    import brm_pkg::*;

    // bits at or above the descriptor width never count
    localparam logic [DESC_MAX-1:0] DESC_MASK = {DESC_MAX{1'b1}} >> (DESC_MAX - DESC_BITS);

    logic [DESC_MAX-1:0] r_query;
    logic [DESC_MAX-1:0] w_diff;
    t_parts              w_parts;
    t_parts              r_parts;

    // query descriptor, replaced on a load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query <= '0;
        end else if (i_load) begin
            r_query <= i_desc & DESC_MASK;
        end
    end

    assign w_diff = (r_query ^ i_desc) & DESC_MASK;

    // per-byte counts summed into four partials
    always_comb begin
        for (int p = 0; p < PART_N; p++) begin
            w_parts[p] = '0;
            for (int b = 0; b < BYTES_PER_PART; b++) begin
                w_parts[p] = w_parts[p]
                    + PART_W'(popcnt8(w_diff[(p * BYTES_PER_PART + b) * 8 +: 8]));
            end
        end
    end

    // partial count register
    always_ff @(posedge i_clk) begin
        if (i_cand) begin
            r_parts <= w_parts;
        end
    end

    assign o_parts = r_parts;

endmodule

[hw/rtl/brm_used_map.sv]
// used-index bitmap: memory, index folding, bypass and clearing sweep
module brm_used_map #(
    parameter int MAX_KEYPOINTS = 2048
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    input  logic                      i_drained,
    input  logic                      i_rd_en,
    input  logic [brm_pkg::IDX_W-1:0] i_rd_idx,
    input  brm_pkg::t_mark            i_mark,
    output logic                      o_used,
    output logic                      o_busy
);
    import brm_pkg::*;

    localparam int SLOT_W = $clog2(MAX_KEYPOINTS);
    localparam int LO_W   = 6;
    localparam int HI_N   = 2 ** (IDX_W - LO_W);
    localparam int LO_N   = 2 ** LO_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_KEYPOINTS - 1);
    localparam logic [SLOT_W:0]   WRAP      = (SLOT_W + 1)'(MAX_KEYPOINTS);

    typedef logic [HI_N-1:0][SLOT_W-1:0] t_hi_tab;
    typedef logic [LO_N-1:0][SLOT_W-1:0] t_lo_tab;
    typedef enum logic {SW_IDLE, SW_RUN} t_sweep_state;

    function automatic t_hi_tab mk_hi_tab();
        t_hi_tab t;
        for (int i = 0; i < HI_N; i++) begin
            t[i] = SLOT_W'((i * LO_N) % MAX_KEYPOINTS);
        end
        return t;
    endfunction

    function automatic t_lo_tab mk_lo_tab();
        t_lo_tab t;
        for (int i = 0; i < LO_N; i++) begin
            t[i] = SLOT_W'(i % MAX_KEYPOINTS);
        end
        return t;
    endfunction

    localparam t_hi_tab HI_TAB = mk_hi_tab();
    localparam t_lo_tab LO_TAB = mk_lo_tab();

    // index modulo map depth: two folded table halves, one correction
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [SLOT_W:0] s;
        s = {1'b0, HI_TAB[idx[IDX_W-1:LO_W]]} + {1'b0, LO_TAB[idx[LO_W-1:0]]};
        if (s >= WRAP) begin
            s = s - WRAP;
        end
        return s[SLOT_W-1:0];
    endfunction

    t_sweep_state      r_state;
    logic [SLOT_W-1:0] r_addr;
    logic              r_used_mem [MAX_KEYPOINTS];
    logic              r_rd_q;
    logic              r_rd_hit;
    logic [SLOT_W-1:0] r_rd_slot;
    logic [SLOT_W-1:0] w_rd_slot;
    logic [SLOT_W-1:0] w_wr_slot;
    logic              w_sweep_we;

    assign w_rd_slot  = slot_of(i_rd_idx);
    assign w_wr_slot  = slot_of(i_mark.idx);
    assign w_sweep_we = (r_state == SW_RUN) && i_drained;

    // clearing sweep, one entry per cycle once the pipeline is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SW_RUN;
            r_addr  <= '0;
        end else begin
            unique case (r_state)
                SW_IDLE: begin
                    if (i_clear) begin
                        r_state <= SW_RUN;
                        r_addr  <= '0;
                    end
                end
                SW_RUN: begin
                    if (i_drained) begin
                        if (r_addr == LAST_SLOT) begin
                            r_state <= SW_IDLE;
                        end
                        r_addr <= r_addr + 1'b1;
                    end
                end
                default: begin
                    r_state <= SW_RUN;
                    r_addr  <= '0;
                end
            endcase
        end
    end

    // bitmap memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (w_sweep_we) begin
            r_used_mem[r_addr] <= 1'b0;
        end else if (i_mark.en) begin
            r_used_mem[w_wr_slot] <= 1'b1;
        end
        if (i_rd_en) begin
            r_rd_q <= r_used_mem[w_rd_slot];
        end
    end

    // bypass for a mark written on the read edge
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_hit  <= i_mark.en && (w_wr_slot == w_rd_slot);
            r_rd_slot <= w_rd_slot;
        end
    end

    // also cover a mark written on the following edge
    assign o_used = r_rd_q | r_rd_hit | (i_mark.en && (w_wr_slot == r_rd_slot));
    assign o_busy = (r_state == SW_RUN);

endmodule

[hw/rtl/brm_search.sv]
// best and runner-up tracking, threshold and ratio decision, result register
module brm_search (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  brm_pkg::t_stage              i_stage,
    input  logic                         i_used,
    input  brm_pkg::t_parts              i_parts,
    input  logic [brm_pkg::CFG_W-1:0]    i_init_dist,
    input  logic [brm_pkg::CFG_W-1:0]    i_thresh,
    input  logic [brm_pkg::CFG_W-1:0]    i_ratio,
    output brm_pkg::t_mark               o_mark,
    output logic                         o_valid,
    output logic [brm_pkg::STATUS_W-1:0] o_status,
    output logic [brm_pkg::IDX_W-1:0]    o_match_index,
    output logic [brm_pkg::DIST_W-1:0]   o_best_distance,
    output logic [brm_pkg::DIST_W-1:0]   o_runner_up_distance
);
    import brm_pkg::*;

    logic [DIST_W-1:0]    r_best;
    logic [DIST_W-1:0]    r_runner;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_found;
    logic                 r_valid;
    t_status              r_status;
    logic [IDX_W-1:0]     r_match_index;
    logic [DIST_W-1:0]    r_best_out;
    logic [DIST_W-1:0]    r_runner_out;

    logic [DIST_W-1:0]    w_dist;
    logic [DIST_W-1:0]    n_best;
    logic [DIST_W-1:0]    n_runner;
    logic [IDX_W-1:0]     n_idx;
    logic                 n_found;
    logic [2*CFG_W-1:0]   w_prod;
    logic [2*CFG_W-1:0]   w_scaled;
    t_status              w_status;
    logic                 w_end;
    logic                 w_restart;

    // final sum of the partial counts
    always_comb begin
        w_dist = '0;
        for (int p = 0; p < PART_N; p++) begin
            w_dist = w_dist + DIST_W'(i_parts[p]);
        end
    end

    // search update, ties keep the earlier best
    always_comb begin
        n_best   = r_best;
        n_runner = r_runner;
        n_idx    = r_idx;
        n_found  = r_found;
        if (i_stage.cand && i_stage.usable && !i_used) begin
            if (w_dist < r_best) begin
                n_runner = r_best;
                n_best   = w_dist;
                n_idx    = i_stage.idx;
                n_found  = 1'b1;
            end else if (w_dist < r_runner) begin
                n_runner = w_dist;
            end
        end
    end

    // threshold and q8 ratio test
    assign w_prod   = (2*CFG_W)'(i_ratio) * (2*CFG_W)'(n_runner);
    assign w_scaled = (2*CFG_W)'(n_best) << Q_FRAC;

    always_comb begin
        if (!n_found || (n_best > i_thresh)) begin
            w_status = ST_REJECT;
        end else if (w_prod < w_scaled) begin
            w_status = ST_RATIO;
        end else begin
            w_status = ST_MATCH;
        end
    end

    assign w_end     = i_stage.cand && i_stage.last;
    assign w_restart = i_stage.load || w_end;

    assign o_mark.en  = w_end && (w_status == ST_MATCH);
    assign o_mark.idx = n_idx;

    // search state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best   <= RST_INIT_DIST;
            r_runner <= RST_INIT_DIST;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= w_end;
            if (w_restart) begin
                r_best   <= i_init_dist;
                r_runner <= i_init_dist;
                r_idx    <= '0;
                r_found  <= 1'b0;
            end else begin
                r_best   <= n_best;
                r_runner <= n_runner;
                r_idx    <= n_idx;
                r_found  <= n_found;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_end) begin
            r_status      <= w_status;
            r_match_index <= n_found ? n_idx : '0;
            r_best_out    <= n_best;
            r_runner_out  <= n_runner;
        end
    end

    assign o_valid              = r_valid;
    assign o_status             = r_status;
    assign o_match_index        = r_match_index;
    assign o_best_distance      = r_best_out;
    assign o_runner_up_distance = r_runner_out;

endmodule

[hw/rtl/binary_descriptor_ratio_matcher_top.sv]
// top level of the binary descriptor ratio matcher
//
// channel   direction  handshake                          payload
// item      in         i_start & !o_busy                  i_func, i_desc_word0..3,
//                                                         i_cand_index, i_cand_usable,
//                                                         i_cand_last
// result    out        o_result_valid, one-cycle strobe   o_status, o_match_index,
//                                                         o_best_distance,
//                                                         o_runner_up_distance
// config    in         i_cfg_valid & o_cfg_ready          i_cfg_index, i_cfg_data
//
// one item per cycle while o_busy is low; the result of a last candidate is strobed after
// its transfer through the input register, partial-count register and result register.
// a clear item holds o_busy while the pipeline drains and then through the bitmap
// sweep over all MAX_KEYPOINTS entries, one entry per cycle.
// after reset o_busy stays high for the bitmap sweep.
// the receiver cannot stall; o_cfg_ready is always high.
module binary_descriptor_ratio_matcher_top #(
    parameter int MAX_KEYPOINTS = 2048,
    parameter int DESC_BITS     = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [brm_pkg::FUNC_W-1:0]    i_func,
    input  logic [brm_pkg::WORD_W-1:0]    i_desc_word0,
    input  logic [brm_pkg::WORD_W-1:0]    i_desc_word1,
    input  logic [brm_pkg::WORD_W-1:0]    i_desc_word2,
    input  logic [brm_pkg::WORD_W-1:0]    i_desc_word3,
    input  logic [brm_pkg::IDX_W-1:0]     i_cand_index,
    input  logic                          i_cand_usable,
    input  logic                          i_cand_last,
    output logic                          o_result_valid,
    output logic [brm_pkg::STATUS_W-1:0]  o_status,
    output logic [brm_pkg::IDX_W-1:0]     o_match_index,
    output logic [brm_pkg::DIST_W-1:0]    o_best_distance,
    output logic [brm_pkg::DIST_W-1:0]    o_runner_up_distance,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [brm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [brm_pkg::CFG_W-1:0]     i_cfg_data
);
    import brm_pkg::*;

    logic [CFG_W-1:0]    r_cfg_init;
    logic [CFG_W-1:0]    r_cfg_thresh;
    logic [CFG_W-1:0]    r_cfg_ratio;
    t_stage              r_s1;
    t_stage              r_s2;
    logic [DESC_MAX-1:0] r_s1_desc;
    logic                r_s2_used;

    logic   w_accept;
    logic   w_drained;
    logic   w_s1_used;
    t_parts w_parts;
    t_mark  w_mark;

    assign w_accept    = i_start && !o_busy;
    assign w_drained   = !(r_s1.load || r_s1.cand || r_s2.load || r_s2.cand);
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_init   <= RST_INIT_DIST;
            r_cfg_thresh <= RST_THRESH;
            r_cfg_ratio  <= RST_RATIO;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_INIT_DIST: r_cfg_init   <= i_cfg_data;
                CFG_THRESH:    r_cfg_thresh <= i_cfg_data;
                CFG_RATIO:     r_cfg_ratio  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control: input stage and search stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1      <= '0;
            r_s2      <= '0;
            r_s2_used <= 1'b0;
        end else begin
            r_s1.load   <= w_accept && (i_func == FUNC_LOAD);
            r_s1.cand   <= w_accept && (i_func == FUNC_CAND);
            r_s1.usable <= i_cand_usable;
            r_s1.last   <= i_cand_last;
            r_s1.idx    <= i_cand_index;
            r_s2        <= r_s1;
            r_s2_used   <= w_s1_used;
        end
    end

    // descriptor input register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_desc <= {i_desc_word3, i_desc_word2, i_desc_word1, i_desc_word0};
        end
    end

    brm_dist #(
        .DESC_BITS (DESC_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_s1.load),
        .i_cand  (r_s1.cand),
        .i_desc  (r_s1_desc),
        .o_parts (w_parts)
    );

    brm_used_map #(
        .MAX_KEYPOINTS (MAX_KEYPOINTS)
    ) u_used_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_accept && (i_func == FUNC_CLEAR)),
        .i_drained (w_drained),
        .i_rd_en   (w_accept && (i_func == FUNC_CAND)),
        .i_rd_idx  (i_cand_index),
        .i_mark    (w_mark),
        .o_used    (w_s1_used),
        .o_busy    (o_busy)
    );

    brm_search u_search (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_stage              (r_s2),
        .i_used               (r_s2_used),
        .i_parts              (w_parts),
        .i_init_dist          (r_cfg_init),
        .i_thresh             (r_cfg_thresh),
        .i_ratio              (r_cfg_ratio),
        .o_mark               (w_mark),
        .o_valid              (o_result_valid),
        .o_status             (o_status),
        .o_match_index        (o_match_index),
        .o_best_distance      (o_best_distance),
        .o_runner_up_distance (o_runner_up_distance)
    );

    // a result comes only from a transferred last candidate, through the input, partial-count and result registers
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |->
            $past(i_start && !o_busy && (i_func == FUNC_CAND) && i_cand_last, 3))
        else $error("result without a matching last candidate");

    // the sweep ends only with an empty pipeline
    a_sweep_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> w_drained)
        else $error("bitmap sweep ended with items in flight");

    // runner-up never beats the best
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_runner_up_distance >= o_best_distance))
        else $error("runner-up distance below best distance");

    // a match is always within the threshold
    a_match_thresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == ST_MATCH)) |-> (o_best_distance <= r_cfg_thresh))
        else $error("match reported above the threshold");

endmodule

[sim/tb.sv]
// self-checking testbench for the binary descriptor ratio matcher
`timescale 1ns / 1ps

module tb;
    import brm_pkg::*;

    localparam int MAX_KP      = 2048;
    localparam int STALL_LIMIT = 20000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [FUNC_W-1:0]    FUNC_NOP  = 2'd3;

    typedef logic [DESC_MAX-1:0] t_desc;

    typedef struct {
        logic [FUNC_W-1:0] func;
        t_desc             desc;
        logic [IDX_W-1:0]  idx;
        logic              usable;
        logic              last;
    } t_item;

    typedef struct {
        t_status           status;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] best;
        logic [DIST_W-1:0] runner;
    } t_verdict;

    // clock, reset and block ports
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_start        = 1'b0;
    logic [FUNC_W-1:0]    i_func         = '0;
    logic [WORD_W-1:0]    i_desc_word0   = '0;
    logic [WORD_W-1:0]    i_desc_word1   = '0;
    logic [WORD_W-1:0]    i_desc_word2   = '0;
    logic [WORD_W-1:0]    i_desc_word3   = '0;
    logic [IDX_W-1:0]     i_cand_index   = '0;
    logic                 i_cand_usable  = 1'b0;
    logic                 i_cand_last    = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 o_busy;
    logic                 o_result_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [IDX_W-1:0]     o_match_index;
    logic [DIST_W-1:0]    o_best_distance;
    logic [DIST_W-1:0]    o_runner_up_distance;
    logic                 o_cfg_ready;

    // stimulus bookkeeping
    t_item    pending_items[$];
    t_verdict expected_verdicts[$];
    int       pushed_count   = 0;
    int       taken_count    = 0;
    int       mismatch_count = 0;
    int       idle_pct       = 0;
    int       quiet_cycles   = 0;
    logic     item_taken     = 1'b0;
    t_desc    gen_query      = '0;

    // predictor copy of the block state and registers
    t_desc             q_desc       = '0;
    logic [DIST_W-1:0] best_d       = RST_INIT_DIST;
    logic [DIST_W-1:0] second_d     = RST_INIT_DIST;
    logic [IDX_W-1:0]  best_at      = '0;
    bit                have_best    = 1'b0;
    bit [MAX_KP-1:0]   used_slots   = '0;
    logic [CFG_W-1:0]  cfg_start    = RST_INIT_DIST;
    logic [CFG_W-1:0]  cfg_accept   = RST_THRESH;
    logic [CFG_W-1:0]  cfg_ratio    = RST_RATIO;

    binary_descriptor_ratio_matcher_top uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .o_busy              (o_busy),
        .i_func              (i_func),
        .i_desc_word0        (i_desc_word0),
        .i_desc_word1        (i_desc_word1),
        .i_desc_word2        (i_desc_word2),
        .i_desc_word3        (i_desc_word3),
        .i_cand_index        (i_cand_index),
        .i_cand_usable       (i_cand_usable),
        .i_cand_last         (i_cand_last),
        .o_result_valid      (o_result_valid),
        .o_status            (o_status),
        .o_match_index       (o_match_index),
        .o_best_distance     (o_best_distance),
        .o_runner_up_distance(o_runner_up_distance),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // search restarts from the start distance, query is kept
    function automatic void restart_search();
        best_d    = cfg_start;
        second_d  = cfg_start;
        best_at   = '0;
        have_best = 1'b0;
    endfunction

    // query load, used-map clear and nearest-neighbor search with threshold and ratio test
    task automatic predict_match(input t_item it);
        int unsigned ham_d;
        int unsigned lhs;
        int unsigned rhs;
        t_verdict    v;
        case (it.func)
            FUNC_LOAD: begin
                q_desc = it.desc;
                restart_search();
            end
            FUNC_CLEAR: used_slots = '0;
            FUNC_CAND: begin
                if (it.usable && !used_slots[it.idx]) begin
                    ham_d = $countones(q_desc ^ it.desc);
                    if (ham_d < best_d) begin
                        second_d  = best_d;
                        best_d    = DIST_W'(ham_d);
                        best_at   = it.idx;
                        have_best = 1'b1;
                    end else if (ham_d < second_d) begin
                        second_d = DIST_W'(ham_d);
                    end
                end
                if (it.last) begin
                    lhs = 32'(cfg_ratio);
                    lhs = lhs * 32'(second_d);
                    rhs = 32'(best_d);
                    rhs = rhs * 256;
                    if (!have_best || best_d > cfg_accept) begin
                        v.status = ST_REJECT;
                    end else if (lhs < rhs) begin
                        v.status = ST_RATIO;
                    end else begin
                        v.status = ST_MATCH;
                        used_slots[best_at] = 1'b1;
                    end
                    v.idx    = have_best ? best_at : '0;
                    v.best   = best_d;
                    v.runner = second_d;
                    expected_verdicts.push_back(v);
                    restart_search();
                end
            end
            default: ;
        endcase
    endtask

    // item driver, one transfer per accepted start
    always @(negedge i_clk) begin
        t_item it;
        if (i_rst_n && (!i_start || item_taken)) begin
            if (pending_items.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
                it = pending_items.pop_front();
                i_func        <= it.func;
                i_desc_word0  <= it.desc[63:0];
                i_desc_word1  <= it.desc[127:64];
                i_desc_word2  <= it.desc[191:128];
                i_desc_word3  <= it.desc[255:192];
                i_cand_index  <= it.idx;
                i_cand_usable <= it.usable;
                i_cand_last   <= it.last;
                i_start       <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: register writes, result checks, prediction and watchdog
    always @(posedge i_clk) begin
        t_verdict want;
        t_item    seen;
        bit       took;
        bit       active;
        took   = i_rst_n && i_start && (o_busy === 1'b0);
        active = took;
        item_taken <= took;

        if (i_rst_n && i_cfg_valid && o_cfg_ready === 1'b1) begin
            active = 1'b1;
            case (i_cfg_index)
                CFG_INIT_DIST: cfg_start  = i_cfg_data;
                CFG_THRESH:    cfg_accept = i_cfg_data;
                CFG_RATIO:     cfg_ratio  = i_cfg_data;
                default: ;
            endcase
        end

        if (i_rst_n && o_result_valid === 1'b1) begin
            active = 1'b1;
            if (expected_verdicts.size() == 0) begin
                report_mismatch("unexpected result, status", 32'(o_status), 0);
            end else begin
                want = expected_verdicts.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_match_index !== want.idx)
                    report_mismatch("match_index", 32'(o_match_index), 32'(want.idx));
                if (o_best_distance !== want.best)
                    report_mismatch("best_distance", 32'(o_best_distance),
                                    32'(want.best));
                if (o_runner_up_distance !== want.runner)
                    report_mismatch("runner_up_distance", 32'(o_runner_up_distance),
                                    32'(want.runner));
            end
        end

        if (took) begin
            seen.func   = i_func;
            seen.desc   = {i_desc_word3, i_desc_word2, i_desc_word1, i_desc_word0};
            seen.idx    = i_cand_index;
            seen.usable = i_cand_usable;
            seen.last   = i_cand_last;
            predict_match(seen);
            taken_count++;
        end

        if (active) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("tb: errors");
                $finish;
            end
        end
    end

    function automatic t_desc rand_desc();
        t_desc d;
        for (int i = 0; i < DESC_MAX / 32; i++) d[i*32 +: 32] = $urandom;
        return d;
    endfunction

    function automatic t_desc flip_bits(input t_desc d, input int n);
        for (int i = 0; i < n; i++) d[$urandom_range(DESC_MAX - 1, 0)] ^= 1'b1;
        return d;
    endfunction

    function automatic t_desc low_ones(input int n);
        return (t_desc'(1) << n) - t_desc'(1);
    endfunction

    // half the time a small index pool so the used map fills up
    function automatic logic [IDX_W-1:0] rand_index();
        if ($urandom_range(1, 0) == 0) return IDX_W'($urandom_range(31, 0));
        return IDX_W'($urandom_range(MAX_KP - 1, 0));
    endfunction

    // candidate close to the current query, sometimes unrelated
    function automatic t_desc rand_cand();
        int r;
        r = $urandom_range(9, 0);
        if (r < 2) return rand_desc();
        if (r < 4) return flip_bits(gen_query, $urandom_range(8, 0));
        return flip_bits(gen_query, $urandom_range(70, 0));
    endfunction

    task automatic push_item(input logic [FUNC_W-1:0] func, input t_desc desc,
                             input logic [IDX_W-1:0] idx, input logic usable,
                             input logic last);
        t_item it;
        it.func   = func;
        it.desc   = desc;
        it.idx    = idx;
        it.usable = usable;
        it.last   = last;
        pending_items.push_back(it);
        pushed_count++;
    endtask

    // query runs with random content, plus noise and broken runs
    task automatic gen_random(input int n);
        int made;
        int r;
        int k;
        made = 0;
        while (made < n) begin
            r = $urandom_range(99, 0);
            if (r < 80) begin
                if ($urandom_range(9, 0) < 7) begin
                    gen_query = rand_desc();
                    push_item(FUNC_LOAD, gen_query, rand_index(), 1'($urandom_range(1, 0)),
                              1'($urandom_range(1, 0)));
                    made++;
                end
                k = $urandom_range(6, 1);
                for (int i = 0; i < k; i++) begin
                    push_item(FUNC_CAND, rand_cand(), rand_index(),
                              $urandom_range(9, 0) != 0, i == k - 1);
                    made++;
                end
            end else if (r < 86) begin
                push_item(FUNC_NOP, rand_desc(), rand_index(), 1'($urandom_range(1, 0)),
                          1'($urandom_range(1, 0)));
            end else if (r < 88) begin
                push_item(FUNC_CLEAR, rand_desc(), rand_index(), 1'($urandom_range(1, 0)),
                          1'($urandom_range(1, 0)));
                made++;
            end else begin
                push_item($urandom_range(1, 0) ? FUNC_CAND : FUNC_LOAD,
                          $urandom_range(1, 0) ? rand_desc() : rand_cand(), rand_index(),
                          1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
                made++;
            end
        end
    endtask

    // wait for every transfer and result, then for the pipeline to drain
    task automatic settle();
        do @(negedge i_clk);
        while (taken_count != pushed_count || expected_verdicts.size() != 0);
        repeat (4) @(negedge i_clk);
        while (o_busy !== 1'b0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] start_d, input logic [CFG_W-1:0] accept,
                            input logic [CFG_W-1:0] ratio);
        write_reg(CFG_INIT_DIST, start_d);
        write_reg(CFG_THRESH, accept);
        write_reg(CFG_RATIO, ratio);
    endtask

    // test sequence
    initial begin
        t_desc q;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed cases at reset register values
        q = rand_desc();
        push_item(FUNC_NOP, '1, '1, 1'b1, 1'b1);
        push_item(FUNC_LOAD, q, '0, 1'b0, 1'b0);
        push_item(FUNC_CAND, q, 11'd2047, 1'b1, 1'b0);
        // tie at zero distance does not replace the best
        push_item(FUNC_CAND, q, 11'd5, 1'b1, 1'b0);
        push_item(FUNC_CAND, ~q, 11'd6, 1'b1, 1'b1);
        // already used index is skipped, nothing found
        push_item(FUNC_CAND, q, 11'd2047, 1'b1, 1'b1);
        push_item(FUNC_CAND, q, 11'd7, 1'b0, 1'b1);
        push_item(FUNC_CLEAR, '1, '1, 1'b1, 1'b1);
        push_item(FUNC_CAND, q, 11'd2047, 1'b1, 1'b1);
        // distance equal to the start value is never accepted
        push_item(FUNC_LOAD, '0, '1, 1'b1, 1'b1);
        push_item(FUNC_CAND, '1, '0, 1'b1, 1'b1);
        // ratio test fails on close runner-up
        push_item(FUNC_CAND, low_ones(10), 11'd1, 1'b1, 1'b0);
        push_item(FUNC_CAND, low_ones(12), 11'd2, 1'b1, 1'b1);
        push_item(FUNC_CAND, low_ones(40), 11'd3, 1'b1, 1'b0);
        push_item(FUNC_CAND, low_ones(200), 11'd4, 1'b1, 1'b1);
        // best right at the threshold, then just above it
        push_item(FUNC_CAND, low_ones(60), 11'd9, 1'b1, 1'b0);
        push_item(FUNC_CAND, low_ones(50), 11'd10, 1'b1, 1'b1);
        push_item(FUNC_CAND, low_ones(51), 11'd11, 1'b1, 1'b1);
        push_item(FUNC_LOAD, '1, '0, 1'b0, 1'b0);
        push_item(FUNC_CAND, '1, '0, 1'b1, 1'b1);
        settle();

        // random runs, sender pauses midway until all results are in
        gen_query = rand_desc();
        idle_pct = 54;
        gen_random(75);
        settle();
        gen_random(75);
        settle();

        set_regs(9'd256, 9'd256, 9'd256);
        idle_pct = 12;
        gen_random(150);
        settle();

        set_regs(9'd0, 9'd0, 9'd0);
        idle_pct = 0;
        gen_random(60);
        settle();

        set_regs(9'd511, 9'd100, 9'd200);
        idle_pct = 54;
        gen_random(150);
        settle();

        write_reg(CFG_SPARE, CFG_W'($urandom));
        set_regs(CFG_W'($urandom_range(256, 100)), CFG_W'($urandom_range(256, 0)),
                 CFG_W'($urandom_range(256, 0)));
        idle_pct = 12;
        gen_random(150);
        settle();

        set_regs(9'd256, 9'd80, 9'd230);
        idle_pct = 0;
        gen_random(200);
        settle();

        if (mismatch_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/brm_pkg.sv
hw/rtl/brm_dist.sv
hw/rtl/brm_used_map.sv
hw/rtl/brm_search.sv
hw/rtl/binary_descriptor_ratio_matcher_top.sv
sim/tb.sv
